// ----- sv/vcbc_pkg.sv -----
// ----------------------------------------------------------------------------
// vcbc_pkg
// Shared types and constants for the valve command and burp controller.
// ----------------------------------------------------------------------------
package vcbc_pkg;

    localparam int SERVO_COUNT    = 4;
    localparam int SOLENOID_COUNT = 2;
    localparam int MASK_W         = 2;   // solenoid masks cover solenoids 0 and 1 only

    // Frame opcodes
    localparam logic [7:0] OP_OPEN       = 8'h01;
    localparam logic [7:0] OP_CLOSE_MOD  = 8'h02;
    localparam logic [7:0] OP_CLOSE_SLOW = 8'h03;
    localparam logic [7:0] OP_CLOSE      = 8'h04;
    localparam logic [7:0] OP_LOW_TEST   = 8'h06;
    localparam logic [7:0] OP_HIGH_TEST  = 8'h07;

    // Item kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_PASS = 1'b1;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_LOW_THR  = 2'd0;
    localparam logic [1:0] REG_HIGH_THR = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;

    localparam logic [15:0] LOW_THR_RST  = 16'd100;
    localparam logic [15:0] HIGH_THR_RST = 16'd9000;
    localparam logic [15:0] INTERVAL_RST = 16'd100;

    localparam int PADDR_W = 4;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  rx_byte;
        logic [15:0] pressure_a;
        logic [15:0] pressure_b;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic              frame_done;
        logic              frame_ok;
        logic              servo_cmd_valid;
        logic [1:0]        servo_index;
        logic [1:0]        servo_action;
        logic [MASK_W-1:0] sol_strobe;
        logic [MASK_W-1:0] sol_open;
        logic              burp_active;
    } out_item_t;

endpackage

// ----- sv/valve_command_and_burp_control.sv -----
// ----------------------------------------------------------------------------
// valve_command_and_burp_control
// Serial frame decoder for servo/solenoid commands plus solenoid burp control.
// ----------------------------------------------------------------------------
// Each accepted beat (serial byte or control pass) yields exactly one result
// beat; a new beat can be accepted every cycle while in_stall is low.
// All state (frame assembly, burp phases, toggle timestamps) is updated in the
// accept cycle, so back-to-back beats see each other's effects. An output
// register plus a one-entry skid stage decouple the two sides: in_stall rises
// only when both hold results the consumer has not taken. Configuration sits
// on the APB port at byte addresses 0x0 (low threshold), 0x4 (high threshold)
// and 0x8 (burp interval, ms); there is no clearing pass after reset.
module valve_command_and_burp_control (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  vcbc_pkg::in_item_t     in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output vcbc_pkg::out_item_t    out_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [vcbc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import vcbc_pkg::*;

    // configuration
    logic [15:0] low_threshold_reg;
    logic [15:0] high_threshold_reg;
    logic [15:0] burp_interval_reg;
    logic        cfg_wr;

    // block state
    logic [7:0]  frame_bytes_reg [2];
    logic [1:0]  byte_count_reg, byte_count_next;
    logic        burp_enabled_reg, burp_enabled_next;
    logic        high_mode_reg, high_mode_next;
    logic [SOLENOID_COUNT-1:0] burp_phase_reg, burp_phase_next;
    logic [SOLENOID_COUNT-1:0] valve_open_reg, valve_open_next;
    logic [31:0] last_toggle_reg [SOLENOID_COUNT];
    logic [31:0] last_toggle_next [SOLENOID_COUNT];

    // output side
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      skid_valid_reg;
    out_item_t skid_data_reg;

    logic      acc;
    logic      out_free;
    out_item_t res;

    // ------------------------------------------------------------------
    // APB
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_threshold_reg  <= LOW_THR_RST;
            high_threshold_reg <= HIGH_THR_RST;
            burp_interval_reg  <= INTERVAL_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_LOW_THR:  low_threshold_reg  <= pwdata[15:0];
                REG_HIGH_THR: high_threshold_reg <= pwdata[15:0];
                REG_INTERVAL: burp_interval_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_LOW_THR:  prdata = {16'd0, low_threshold_reg};
            REG_HIGH_THR: prdata = {16'd0, high_threshold_reg};
            REG_INTERVAL: prdata = {16'd0, burp_interval_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Per-beat logic
    // ------------------------------------------------------------------
    assign acc = in_valid && !in_stall;

    always_comb
    begin
        logic [7:0]  id;
        logic [7:0]  op;
        logic [15:0] thr;
        logic [15:0] p;
        logic [31:0] elapsed;
        logic        hit;

        id      = frame_bytes_reg[0];
        op      = frame_bytes_reg[1];
        thr     = high_mode_reg ? high_threshold_reg : low_threshold_reg;
        p       = 16'd0;
        elapsed = 32'd0;
        hit     = 1'b0;

        byte_count_next   = byte_count_reg;
        burp_enabled_next = burp_enabled_reg;
        high_mode_next    = high_mode_reg;
        burp_phase_next   = burp_phase_reg;
        valve_open_next   = valve_open_reg;
        for (int i = 0; i < SOLENOID_COUNT; i++)
        begin
            last_toggle_next[i] = last_toggle_reg[i];
        end

        res = '0;

        if (in_data.cmd == CMD_BYTE)
        begin
            if (byte_count_reg < 2'd2)
            begin
                byte_count_next = byte_count_reg + 2'd1;
            end
            else
            begin
                byte_count_next = 2'd0;
                res.frame_done  = 1'b1;
                if ((id ^ op) == in_data.rx_byte)
                begin
                    if (id < 8'(SERVO_COUNT))
                    begin
                        if (op >= OP_OPEN && op <= OP_CLOSE)
                        begin
                            res.frame_ok        = 1'b1;
                            res.servo_cmd_valid = 1'b1;
                            res.servo_index     = id[1:0];
                            res.servo_action    = 2'(op - OP_OPEN);
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < SOLENOID_COUNT; i++)
                        begin
                            hit = (id == 8'(SERVO_COUNT + i));
                            if (hit)
                            begin
                                case (op)
                                    OP_OPEN:
                                    begin
                                        valve_open_next[i] = 1'b1;
                                        if (i < MASK_W) res.sol_strobe[i] = 1'b1;
                                        res.frame_ok = 1'b1;
                                    end
                                    OP_CLOSE:
                                    begin
                                        valve_open_next[i] = 1'b0;
                                        burp_enabled_next  = 1'b0;
                                        if (i < MASK_W) res.sol_strobe[i] = 1'b1;
                                        res.frame_ok = 1'b1;
                                    end
                                    OP_LOW_TEST:
                                    begin
                                        high_mode_next    = 1'b0;
                                        burp_enabled_next = 1'b1;
                                        res.frame_ok      = 1'b1;
                                    end
                                    OP_HIGH_TEST:
                                    begin
                                        high_mode_next    = 1'b1;
                                        burp_enabled_next = 1'b1;
                                        res.frame_ok      = 1'b1;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                    end
                end
            end
        end
        else
        begin
            for (int i = 0; i < SOLENOID_COUNT; i++)
            begin
                // solenoids past the second have no sensor: pressure reads 0
                if (i == 0)      p = in_data.pressure_a;
                else if (i == 1) p = in_data.pressure_b;
                else             p = 16'd0;
                elapsed = in_data.now_ms - last_toggle_reg[i];
                if (burp_enabled_reg && (p > thr))
                begin
                    if (elapsed >= {16'd0, burp_interval_reg})
                    begin
                        last_toggle_next[i] = in_data.now_ms;
                        burp_phase_next[i]  = !burp_phase_reg[i];
                        valve_open_next[i]  = !burp_phase_reg[i];
                        if (i < MASK_W) res.sol_strobe[i] = 1'b1;
                    end
                end
                else if (burp_phase_reg[i])
                begin
                    burp_phase_next[i] = 1'b0;
                    valve_open_next[i] = 1'b0;
                    if (i < MASK_W) res.sol_strobe[i] = 1'b1;
                end
            end
        end

        for (int i = 0; i < MASK_W; i++)
        begin
            if (i < SOLENOID_COUNT) res.sol_open[i] = valve_open_next[i];
        end
        res.burp_active = burp_enabled_next;
    end

    // frame bytes: payload only, no reset
    always_ff @(posedge clk)
    begin
        if (acc && in_data.cmd == CMD_BYTE && byte_count_reg < 2'd2)
        begin
            frame_bytes_reg[byte_count_reg[0]] <= in_data.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= 2'd0;
            burp_enabled_reg <= 1'b0;
            high_mode_reg    <= 1'b0;
            burp_phase_reg   <= '0;
            valve_open_reg   <= '0;
            for (int i = 0; i < SOLENOID_COUNT; i++)
            begin
                last_toggle_reg[i] <= 32'd0;
            end
        end
        else if (acc)
        begin
            byte_count_reg   <= byte_count_next;
            burp_enabled_reg <= burp_enabled_next;
            high_mode_reg    <= high_mode_next;
            burp_phase_reg   <= burp_phase_next;
            valve_open_reg   <= valve_open_next;
            for (int i = 0; i < SOLENOID_COUNT; i++)
            begin
                last_toggle_reg[i] <= last_toggle_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register + skid
    // ------------------------------------------------------------------
    assign in_stall  = skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || acc;
            skid_valid_reg <= 1'b0;
        end
        else if (acc)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg) out_data_reg <= skid_data_reg;
            else if (acc)       out_data_reg <= res;
        end
        else if (acc)
        begin
            skid_data_reg <= res;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output register is empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg != 2'd3)
        else $error("frame byte count out of range");

    a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_ok |-> out_data.frame_done)
        else $error("frame_ok without a completed frame");

    a_servo_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.servo_cmd_valid |-> out_data.frame_ok)
        else $error("servo command from a rejected frame");

    a_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && skid_valid_reg |=> skid_valid_reg && out_valid)
        else $error("buffered beat lost while output stalled");

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for valve_command_and_burp_control. A short table of directed
// beats (reset state, field extremes, every frame kind, burp toggle and the
// forced close) runs first. Random frames and control passes then run under
// several threshold and interval settings and idle patterns. Every result beat
// is checked field by field against the typed expectation of its table row, or
// else against an in-bench model of the decoder and the burp logic.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vcbc_pkg::*;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } step_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    in_item_t            in_data;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_item_t           out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // typed-in expectation that travels with the beat on in_data
    logic                row_typed;
    out_item_t           row_want;

    // model copy of the configuration
    logic [15:0] thr_low  = LOW_THR_RST;
    logic [15:0] thr_high = HIGH_THR_RST;
    logic [15:0] flip_gap = INTERVAL_RST;

    // model copy of the block state
    logic [7:0]  frm_hold [2];
    int          frm_cnt = 0;
    logic        burp_on = 1'b0;
    logic        use_high = 1'b0;
    logic        burp_ph [SOLENOID_COUNT] = '{default: 1'b0};
    logic [31:0] last_flip [SOLENOID_COUNT] = '{default: 32'd0};
    logic        valve_is_open [SOLENOID_COUNT] = '{default: 1'b0};

    out_item_t   outcome_fifo [$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          frame_pos = 0;
    logic [31:0] clock_ms = 32'd0;
    step_t       plan [0:26];

    valve_command_and_burp_control dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // frame decode and burp update for one beat
    function automatic out_item_t valve_outcome(input in_item_t it);
        out_item_t   r;
        logic [7:0]  id;
        logic [7:0]  op;
        logic [15:0] thr;
        logic [15:0] p;
        int          s;
        r = '0;
        if (it.cmd == CMD_BYTE)
        begin
            if (frm_cnt < 2)
            begin
                frm_hold[frm_cnt] = it.rx_byte;
                frm_cnt++;
            end
            else
            begin
                id = frm_hold[0];
                op = frm_hold[1];
                frm_cnt = 0;
                r.frame_done = 1'b1;
                if ((id ^ op) == it.rx_byte)
                begin
                    if (id < SERVO_COUNT)
                    begin
                        if (op >= OP_OPEN && op <= OP_CLOSE)
                        begin
                            r.frame_ok        = 1'b1;
                            r.servo_cmd_valid = 1'b1;
                            r.servo_index     = id[1:0];
                            r.servo_action    = 2'(op - OP_OPEN);
                        end
                    end
                    else if (int'(id) - SERVO_COUNT < SOLENOID_COUNT)
                    begin
                        s = int'(id) - SERVO_COUNT;
                        case (op)
                            OP_OPEN:
                            begin
                                valve_is_open[s] = 1'b1;
                                r.sol_strobe[s]  = 1'b1;
                                r.frame_ok       = 1'b1;
                            end
                            OP_CLOSE:
                            begin
                                valve_is_open[s] = 1'b0;
                                burp_on          = 1'b0;
                                r.sol_strobe[s]  = 1'b1;
                                r.frame_ok       = 1'b1;
                            end
                            OP_LOW_TEST:
                            begin
                                use_high   = 1'b0;
                                burp_on    = 1'b1;
                                r.frame_ok = 1'b1;
                            end
                            OP_HIGH_TEST:
                            begin
                                use_high   = 1'b1;
                                burp_on    = 1'b1;
                                r.frame_ok = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
        end
        else
        begin
            thr = use_high ? thr_high : thr_low;
            for (int i = 0; i < SOLENOID_COUNT; i++)
            begin
                p = (i == 0) ? it.pressure_a : it.pressure_b;
                if (burp_on && p > thr)
                begin
                    // elapsed time wraps modulo 2^32
                    if (32'(it.now_ms - last_flip[i]) >= {16'd0, flip_gap})
                    begin
                        last_flip[i]     = it.now_ms;
                        burp_ph[i]       = !burp_ph[i];
                        valve_is_open[i] = burp_ph[i];
                        r.sol_strobe[i]  = 1'b1;
                    end
                end
                else if (burp_ph[i])
                begin
                    burp_ph[i]       = 1'b0;
                    valve_is_open[i] = 1'b0;
                    r.sol_strobe[i]  = 1'b1;
                end
            end
        end
        r.sol_open    = {valve_is_open[1], valve_is_open[0]};
        r.burp_active = burp_on;
        return r;
    endfunction

    function automatic bit agrees(input out_item_t a, input out_item_t b);
        return a.frame_done === b.frame_done && a.frame_ok === b.frame_ok
            && a.servo_cmd_valid === b.servo_cmd_valid
            && a.servo_index === b.servo_index && a.servo_action === b.servo_action
            && a.sol_strobe === b.sol_strobe && a.sol_open === b.sol_open
            && a.burp_active === b.burp_active;
    endfunction

    function automatic string show(input out_item_t r);
        return $sformatf("done=%b ok=%b servo=%b idx=%0d act=%0d strobe=%b open=%b burp=%b",
                         r.frame_done, r.frame_ok, r.servo_cmd_valid, r.servo_index,
                         r.servo_action, r.sol_strobe, r.sol_open, r.burp_active);
    endfunction

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin : watch
        out_item_t want;
        out_item_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (outcome_fifo.size() == 0)
                begin
                    flag_mismatch($sformatf("result beat with none pending: %s", show(out_data)));
                end
                else
                begin
                    want = outcome_fifo.pop_front();
                    if (!agrees(want, out_data))
                        flag_mismatch($sformatf("expected %s / got %s", show(want),
                                                show(out_data)));
                end
            end
            if (in_valid && !in_stall)
            begin
                got = valve_outcome(in_data);
                outcome_fifo.push_back(row_typed ? row_want : got);
            end
        end
    end

    function automatic in_item_t rx(input logic [7:0] b);
        in_item_t it;
        it = '0;
        it.cmd = CMD_BYTE;
        it.rx_byte = b;
        return it;
    endfunction

    function automatic in_item_t tick(input logic [15:0] pa, input logic [15:0] pb,
                                      input logic [31:0] t);
        in_item_t it;
        it = '0;
        it.cmd = CMD_PASS;
        it.pressure_a = pa;
        it.pressure_b = pb;
        it.now_ms = t;
        return it;
    endfunction

    function automatic out_item_t res(input logic done, input logic ok, input logic sv,
                                      input logic [1:0] idx, input logic [1:0] act,
                                      input logic [1:0] strobe, input logic [1:0] opn,
                                      input logic burp);
        return '{done, ok, sv, idx, act, strobe, opn, burp};
    endfunction

    function automatic step_t plain(input in_item_t it);
        return '{it, 1'b0, '0};
    endfunction

    function automatic step_t known(input in_item_t it, input out_item_t w);
        return '{it, 1'b1, w};
    endfunction

    task automatic drive_beat(input in_item_t it, input logic typed, input out_item_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_data   <= it;
        row_typed <= typed;
        row_want  <= want;
        if (it.cmd == CMD_BYTE)
            frame_pos = (frame_pos == 2) ? 0 : frame_pos + 1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_byte(input logic [7:0] b);
        in_item_t it;
        it = rx(b);
        it.pressure_a = 16'($urandom);
        it.pressure_b = 16'($urandom);
        it.now_ms = $urandom;
        drive_beat(it, 1'b0, '0);
    endtask

    function automatic logic [15:0] near_threshold();
        logic [15:0] thr;
        thr = $urandom_range(1) ? thr_high : thr_low;
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return thr;
            3:       return thr + 16'd1;
            4:       return thr - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pass();
        in_item_t it;
        case ($urandom_range(9))
            0:       clock_ms += $urandom;
            1, 2:    ;
            default: clock_ms += $urandom_range(0, 32'(flip_gap) * 2 + 2);
        endcase
        it = tick(near_threshold(), near_threshold(), clock_ms);
        it.rx_byte = 8'($urandom);
        drive_beat(it, 1'b0, '0);
    endtask

    task automatic random_traffic(input int n);
        int         sent;
        int         k;
        logic [7:0] id;
        logic [7:0] op;
        logic [7:0] chk;
        sent = 0;
        while (sent < n)
        begin
            k = $urandom_range(99);
            if (k < 50)
            begin
                // realign before a well-formed frame
                while (frame_pos != 0)
                begin
                    send_byte(8'($urandom));
                    sent++;
                end
                if ($urandom_range(99) < 40)
                begin
                    id = 8'($urandom_range(SERVO_COUNT - 1));
                    op = OP_OPEN + 8'($urandom_range(3));
                end
                else
                begin
                    id = 8'(SERVO_COUNT + $urandom_range(SOLENOID_COUNT - 1));
                    k = $urandom_range(99);
                    op = (k < 20) ? OP_OPEN : (k < 35) ? OP_CLOSE :
                         (k < 65) ? OP_LOW_TEST : OP_HIGH_TEST;
                end
                chk = id ^ op;
                send_byte(id);
                send_byte(op);
                send_byte(chk);
                sent += 3;
            end
            else if (k < 85)
            begin
                send_pass();
                sent++;
            end
            else if (k < 95)
            begin
                id = 8'($urandom_range(SERVO_COUNT + SOLENOID_COUNT - 1));
                op = 8'($urandom);
                chk = id ^ op;
                case ($urandom_range(2))
                    0: chk = chk ^ 8'($urandom_range(1, 255));
                    1:
                    begin
                        id = 8'($urandom_range(SERVO_COUNT + SOLENOID_COUNT, 255));
                        chk = id ^ op;
                    end
                    default: ;
                endcase
                send_byte(id);
                send_byte(op);
                send_byte(chk);
                sent += 3;
            end
            else
            begin
                send_byte(8'($urandom));
                sent++;
            end
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_LOW_THR:  thr_low  = val;
            REG_HIGH_THR: thr_high = val;
            REG_INTERVAL: flip_gap = val;
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[15:0] !== val)
            flag_mismatch($sformatf("register %0d read back %h, wrote %h", idx,
                                    prdata[15:0], val));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_cfg(input logic [15:0] lo, input logic [15:0] hi,
                            input logic [15:0] gap);
        cfg_write(REG_LOW_THR, lo);
        cfg_write(REG_HIGH_THR, hi);
        cfg_write(REG_INTERVAL, gap);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outcome_fifo.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        row_typed = 1'b0;
        row_want  = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;

        plan = '{
            // burp off after reset: nothing moves
            known(tick(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF), '0),
            plain(rx(8'h00)), plain(rx(OP_OPEN)),
            known(rx(8'h01), res(1'b1, 1'b1, 1'b1, 2'd0, 2'd0, 2'b00, 2'b00, 1'b0)),
            plain(rx(8'h02)), plain(rx(OP_CLOSE_SLOW)), plain(rx(8'h01)),
            plain(rx(8'h03)), plain(rx(OP_CLOSE)),
            known(rx(8'h07), res(1'b1, 1'b1, 1'b1, 2'd3, 2'd3, 2'b00, 2'b00, 1'b0)),
            // checksum mismatch
            plain(rx(8'h02)), plain(rx(OP_CLOSE_MOD)),
            known(rx(8'hFF), res(1'b1, 1'b0, 1'b0, 2'd0, 2'd0, 2'b00, 2'b00, 1'b0)),
            // burp command sent to a servo id is rejected
            plain(rx(8'h01)), plain(rx(OP_LOW_TEST)), plain(rx(8'h07)),
            plain(rx(8'h04)), plain(rx(OP_OPEN)),
            known(rx(8'h05), res(1'b1, 1'b1, 1'b0, 2'd0, 2'd0, 2'b01, 2'b01, 1'b0)),
            plain(rx(8'h05)), plain(rx(OP_HIGH_TEST)), plain(rx(8'h02)),
            // pressure b equal to threshold does not burp
            plain(tick(16'hFFFF, HIGH_THR_RST, 32'hFFFF_FFFF)),
            plain(rx(8'h04)), plain(rx(OP_CLOSE)), plain(rx(8'h00)),
            // burp now off: solenoid with phase set is forced closed
            plain(tick(16'h0000, 16'h0000, 32'h0000_0000))
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
            drive_beat(plan[k].item, plan[k].typed, plan[k].want);

        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            case (ph)
                0: ;
                1: load_cfg(16'h0000, 16'hFFFF, 16'd1);
                2: load_cfg(16'hFFFF, 16'h0000, 16'hFFFF);
                3: load_cfg(16'h0000, 16'h0000, 16'd0);
                4: load_cfg(16'($urandom_range(2000)), 16'($urandom_range(20000)),
                            16'($urandom_range(1, 300)));
                5: load_cfg(16'd500, 16'd1000, 16'd0);
                6: load_cfg(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)));
                default: load_cfg(LOW_THR_RST, HIGH_THR_RST, INTERVAL_RST);
            endcase
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 64;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 64;
                end
                default:
                begin
                    send_idle_pct = 13;
                    stall_pct = 13;
                end
            endcase
            // start some phases just short of the ms counter wrap
            clock_ms = $urandom_range(1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(300);
            random_traffic(175);
        end
        settle();

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
